/* sv/mwo_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the oscillator.
`timescale 1ns / 1ps
package mwo_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TABLE_BITS  = 8;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int TAB_N       = 1 << TABLE_BITS;
   localparam int WAVE_BITS   = SAMPLE_BITS + 1;   // holds -1.0 .. +1.0 in Q1.F
   localparam int INC_BITS    = 32;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 15;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic signed [WAVE_BITS-1:0] ONE_Q     = WAVE_BITS'(1 << FRAC_BITS);
   localparam logic signed [WAVE_BITS-1:0] NEG_ONE_Q = -ONE_Q;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int TAB_SHIFT = 31 - SAMPLE_BITS;

   localparam logic [INC_BITS-1:0]  INC_RESET  = 32'd42852282;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd32768;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAW      = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      REG_ENABLE    = 2'd0,
      REG_WAVEFORM  = 2'd1,
      REG_PHASE_INC = 2'd2,
      REG_GAIN      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic restart;
      logic final_req;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          wrapped;
      logic                          last;
   } rsp_payload_type;

   typedef struct packed {
      logic                 enable;
      wave_type             waveform;
      logic [INC_BITS-1:0]  phase_increment;
      logic [GAIN_BITS-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic signed [WAVE_BITS-1:0] wave;
      logic                        wrapped;
      logic                        last;
   } wave_stage_type;

   typedef logic [SAMPLE_BITS-1:0] qtab_type [0:TAB_N];

   // Q30 sine over 0..pi/2, Taylor series up to x^13 (elaboration only)
   function automatic logic signed [63:0] sin_q30(logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc  = acc + signed'(term);
      return acc;
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type           tab;
      logic [63:0]        x;
      logic signed [63:0] s;
      logic signed [63:0] v;
      int                 k;
      for (k = 0; k <= TAB_N; k++) begin
         x = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
         s = sin_q30(x);
         if (s < 0) begin
            s = 0;
         end
         v = (s + (64'sd1 <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
         if (v > 64'(ONE_Q)) begin
            v = 64'(ONE_Q);
         end
         tab[k] = SAMPLE_BITS'(v);
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

/* sv/mwo_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module mwo_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mwo_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output mwo_pkg::cfg_type                   cfg
);
   import mwo_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_ENABLE:    cfg_in.enable          = csr_pwdata[0];
            REG_WAVEFORM:  cfg_in.waveform        = wave_type'(csr_pwdata[1:0]);
            REG_PHASE_INC: cfg_in.phase_increment = csr_pwdata[INC_BITS-1:0];
            REG_GAIN:      cfg_in.gain            = csr_pwdata[GAIN_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.waveform        <= WAVE_SINE;
         cfg_ff.phase_increment <= INC_RESET;
         cfg_ff.gain            <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_ENABLE:    csr_prdata = CSR_DATA_BITS'(cfg_ff.enable);
         REG_WAVEFORM:  csr_prdata = CSR_DATA_BITS'(cfg_ff.waveform);
         REG_PHASE_INC: csr_prdata = CSR_DATA_BITS'(cfg_ff.phase_increment);
         REG_GAIN:      csr_prdata = CSR_DATA_BITS'(cfg_ff.gain);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* sv/mwo_phase_wave.sv */
// Input stage: phase accumulator and wave shaping from the current phase.
`timescale 1ns / 1ps
module mwo_phase_wave #(
   parameter int PHASE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mwo_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mwo_pkg::req_payload_type req_payload,
   input  logic                     advance,
   output logic                     wave_valid,
   output mwo_pkg::wave_stage_type  wave_stage
);
   import mwo_pkg::*;

   localparam int ADDR_BITS = TABLE_BITS + 1;

   logic [PHASE_BITS-1:0]   phase_ff;
   logic [PHASE_BITS-1:0]   phase_in;
   logic                    valid_ff;
   logic                    valid_in;
   wave_stage_type          stage_ff;
   wave_stage_type          stage_in;

   logic                    accept;
   logic                    take;
   logic [PHASE_BITS-1:0]   p;
   logic [PHASE_BITS:0]     sum;
   logic [TABLE_BITS+1:0]   top;
   logic [ADDR_BITS-1:0]    tab_addr;
   logic signed [WAVE_BITS-1:0] sine;
   logic signed [WAVE_BITS-1:0] square;
   logic signed [WAVE_BITS-1:0] saw;
   logic signed [WAVE_BITS-1:0] saw_abs;
   logic signed [WAVE_BITS:0]   tri_wide;
   logic signed [WAVE_BITS-1:0] wave;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && cfg.enable;

   assign p   = req_payload.restart ? '0 : phase_ff;
   assign sum = {1'b0, p} + {1'b0, PHASE_BITS'(cfg.phase_increment)};

   // sine: quadrant from the top two bits, mirrored index in odd quadrants
   assign top      = p[PHASE_BITS-1 -: TABLE_BITS+2];
   assign tab_addr = top[TABLE_BITS] ? ADDR_BITS'(TAB_N) - {1'b0, top[TABLE_BITS-1:0]}
                                     : {1'b0, top[TABLE_BITS-1:0]};
   always_comb begin
      if (top[TABLE_BITS+1]) begin
         sine = -signed'({1'b0, QTAB[tab_addr]});
      end else begin
         sine = signed'({1'b0, QTAB[tab_addr]});
      end
   end

   assign square   = ((p != '0) && !p[PHASE_BITS-1]) ? ONE_Q : NEG_ONE_Q;
   assign saw      = WAVE_BITS'(signed'(p[PHASE_BITS-1 -: SAMPLE_BITS]));
   assign saw_abs  = saw[WAVE_BITS-1] ? -saw : saw;
   assign tri_wide = (signed'({saw_abs, 1'b0})) - (WAVE_BITS+1)'(ONE_Q);

   always_comb begin
      case (cfg.waveform)
         WAVE_SINE:     wave = sine;
         WAVE_SQUARE:   wave = square;
         WAVE_TRIANGLE: wave = tri_wide[WAVE_BITS-1:0];
         WAVE_SAW:      wave = saw;
         default:       wave = sine;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      stage_in = stage_ff;
      valid_in = valid_ff && !advance;
      if (take) begin
         phase_in         = sum[PHASE_BITS-1:0];
         stage_in.wave    = wave;
         stage_in.wrapped = sum[PHASE_BITS];
         stage_in.last    = req_payload.final_req;
         valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign wave_valid = valid_ff;
   assign wave_stage = stage_ff;

endmodule

/* sv/mwo_scale.sv */
// Output stage: gain multiply, round half up, saturate, result register.
`timescale 1ns / 1ps
module mwo_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [mwo_pkg::GAIN_BITS-1:0] gain,
   input  logic                     wave_valid,
   input  mwo_pkg::wave_stage_type  wave_stage,
   output logic                     advance,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mwo_pkg::rsp_payload_type rsp_payload
);
   import mwo_pkg::*;

   localparam int PROD_BITS  = WAVE_BITS + GAIN_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int SHIFT_BITS = SUM_BITS - GAIN_FRAC;
   localparam logic signed [SHIFT_BITS-1:0] SAT_HI = SHIFT_BITS'((1 << FRAC_BITS) - 1);
   localparam logic signed [SHIFT_BITS-1:0] SAT_LO = -SHIFT_BITS'(1 << FRAC_BITS);

   logic                        valid_ff;
   logic                        valid_in;
   rsp_payload_type             out_ff;
   rsp_payload_type             out_in;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [SUM_BITS-1:0]  rounded;
   logic signed [SHIFT_BITS-1:0] scaled;
   logic signed [SAMPLE_BITS-1:0] sat;

   assign advance = !valid_ff || !rsp_stall;

   assign prod    = PROD_BITS'(wave_stage.wave) * PROD_BITS'(signed'({1'b0, gain}));
   assign rounded = SUM_BITS'(prod) + SUM_BITS'(1 << (GAIN_FRAC - 1));
   assign scaled  = SHIFT_BITS'(rounded >>> GAIN_FRAC);

   always_comb begin
      if (scaled > SAT_HI) begin
         sat = SAT_HI[SAMPLE_BITS-1:0];
      end else if (scaled < SAT_LO) begin
         sat = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat = scaled[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      out_in   = out_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = wave_valid;
         if (wave_valid) begin
            out_in.sample  = sat;
            out_in.wrapped = wave_stage.wrapped;
            out_in.last    = wave_stage.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* sv/multi_waveform_oscillator_core.sv */
// Top level of the multi-waveform DDS oscillator.
//
// Usage:
//  - req channel: one item per sample tick (restart, final_req). restart zeroes
//    the phase before this sample is formed; final_req comes back as last.
//  - rsp channel: one item per accepted tick while enable is set: the signed
//    sample, wrapped (accumulator carried out after this sample) and last.
//    With enable clear, ticks are taken and dropped and the phase holds.
//  - csr port: APB-style, regs at byte 0 enable, 4 waveform, 8 phase
//    increment, 12 gain (Q1.15). pready is tied high. Write only when idle.
// Timing:
//  - Two register stages: phase/wave stage, then gain/round/saturate stage.
//    Each sample passes the wave stage register, then the output register.
//  - Throughput is one item per cycle while rsp does not stall; the single
//    phase add per tick is the loop that sets it.
//  - When rsp stalls, the output register holds; an empty wave stage still
//    takes one more tick, then req_stall stays high until rsp drains.
// Reset (synchronous): phase 0, pipeline empty, enable 0, sine, default
// increment and unity gain.
`timescale 1ns / 1ps
module multi_waveform_oscillator_core #(
   parameter int PHASE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mwo_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mwo_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mwo_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import mwo_pkg::*;

   cfg_type        cfg;
   logic           advance;     // output stage can take the wave stage's item
   logic           wave_valid;
   wave_stage_type wave_stage;

   mwo_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage 1: phase accumulate and wave shape
   mwo_phase_wave #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase_wave (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .wave_valid  (wave_valid),
      .wave_stage  (wave_stage)
   );

   // stage 2: amplitude scale and output register
   mwo_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .gain        (cfg.gain),
      .wave_valid  (wave_valid),
      .wave_stage  (wave_stage),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sv/mwo_checker.sv */
// Port-level assertions for the oscillator, bound to the top level.
`timescale 1ns / 1ps
module mwo_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input mwo_pkg::req_payload_type           req_payload,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input mwo_pkg::rsp_payload_type           rsp_payload,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [mwo_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [mwo_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                               csr_pready
);
   import mwo_pkg::*;

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   // pipeline comes out of reset empty and open
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // input only backs up when the output is held
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("req stalled with free output");

   // every csr access completes in its first access cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable |-> csr_pready)
      else $error("csr access not completed");

endmodule

bind multi_waveform_oscillator_core mwo_checker u_checker (.*);
